FILE: design/fvm_pkg.sv
package fvm_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int IDX_W        = $clog2(SECTOR_BYTES);
    localparam int CAP_SHIFT    = $clog2(SECTOR_BYTES / 4);
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // byte offsets in a boot sector or MBR
    localparam int OFS_JUMP  = 0;
    localparam int OFS_BPS   = 11;
    localparam int OFS_SPC   = 13;
    localparam int OFS_RSV   = 14;
    localparam int OFS_NFATS = 16;
    localparam int OFS_FAT16 = 22;
    localparam int OFS_TOTAL = 32;
    localparam int OFS_FAT32 = 36;
    localparam int OFS_ROOT  = 44;
    localparam int OFS_PTYPE = 446 + 4;
    localparam int OFS_PLBA  = 446 + 8;
    localparam int OFS_SIG   = 510;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_FAIL  = 2'd2;

    localparam logic [1:0] ST_MOUNTED   = 2'd0;
    localparam logic [1:0] ST_NEED_PART = 2'd1;
    localparam logic [1:0] ST_NO_FS     = 2'd2;
    localparam logic [1:0] ST_IO_ERR    = 2'd3;

    localparam logic [7:0]  JMP_SHORT      = 8'hEB;
    localparam logic [7:0]  JMP_NEAR       = 8'hE9;
    localparam logic [7:0]  TYPE_FAT32_CHS = 8'h0B;
    localparam logic [7:0]  TYPE_FAT32_LBA = 8'h0C;
    localparam logic [15:0] BOOT_SIG       = 16'hAA55;
    localparam logic [31:0] MAX_CLUS_CAP   = 32'h0FFF_FFEF;

    typedef struct packed {
        logic [7:0]  first_byte;
        logic [15:0] bytes_per_sector;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_count;
        logic [7:0]  fat_copies;
        logic [15:0] fat16_size;
        logic [31:0] total_sectors;
        logic [31:0] fat32_size;
        logic [31:0] root_cluster;
        logic [7:0]  part_type;
        logic [31:0] part_lba;
        logic [15:0] signature;
    } bpb_fields_t;

    typedef struct packed {
        logic       clear;
        logic       write;
        logic [7:0] data;
    } cap_ctrl_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

FILE: design/fat32_volume_mount_parser_core.sv
// FAT32 volume mount parser.
// Input beats carry a command and a sector byte: begin (clears the parse, no
// result), byte (next byte of the current sector, offset counted inside) and
// read failure (gives a read error result). Bytes of a sector are taken one
// per cycle while s_ready is high. After the last byte of a sector the block
// drops s_ready and decides the layout: an immediate result for a partition
// request or a rejected volume, or the full FAT32 geometry for a valid boot
// sector, worked out through the 32-step divider that gives the cluster count.
// The result channel has one output register. s_ready is low whenever that
// register holds a beat that is not being taken in the same cycle, so a
// stalled receiver stalls the input side; nothing is dropped.
// Status 1 asks for the partition boot sector at m_request_lba; feed its
// bytes next. After a final status (mounted, no filesystem, read error)
// further bytes and failures are ignored until a begin beat.
// Reset (aresetn low, synchronous) clears the sequencer, the byte offset,
// the captured fields and the result valid flag.
module fat32_volume_mount_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_request_lba,
    output logic [31:0] m_fat_start,
    output logic [31:0] m_data_start,
    output logic [7:0]  m_sec_per_clus,
    output logic [31:0] m_root_clus,
    output logic [7:0]  m_num_fats,
    output logic [31:0] m_fat_size,
    output logic [27:0] m_max_clus
);
    import fvm_pkg::*;

    localparam logic [3:0] S_BYTES = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_DSEC  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_CLAMP = 4'd6;
    localparam logic [3:0] S_CAP   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic        in_part_reg, in_part_next;
    logic [31:0] part_base_reg, part_base_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] fat_start_reg, fat_start_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] data_start_reg, data_start_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] maxc_reg, maxc_next;
    logic [31:0] cap_reg, cap_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_request_lba_reg, m_request_lba_next;
    logic [31:0] m_fat_start_reg, m_fat_start_next;
    logic [31:0] m_data_start_reg, m_data_start_next;
    logic [7:0]  m_sec_per_clus_reg, m_sec_per_clus_next;
    logic [31:0] m_root_clus_reg, m_root_clus_next;
    logic [7:0]  m_num_fats_reg, m_num_fats_next;
    logic [31:0] m_fat_size_reg, m_fat_size_next;
    logic [27:0] m_max_clus_reg, m_max_clus_next;

    bpb_fields_t fld;
    cap_ctrl_t   cap_ctrl;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        last_byte;
    logic        out_free;
    logic        accept;
    logic        byte_go;
    logic        fail_go;
    logic        begin_go;
    logic        sig_ok;
    logic        jump_ok;
    logic        bps_ok;
    logic        bpb_ok;
    logic        type_ok;
    logic        mounted;
    logic [39:0] prod_full;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_BYTES) && out_free;
    assign accept   = s_valid && s_ready;
    assign begin_go = accept && (s_cmd == CMD_BEGIN);
    assign byte_go  = accept && (s_cmd == CMD_BYTE) && !done_reg;
    assign fail_go  = accept && (s_cmd == CMD_FAIL) && !done_reg;

    assign cap_ctrl.clear = begin_go;
    assign cap_ctrl.write = byte_go;
    assign cap_ctrl.data  = s_data_byte;

    fvm_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cap_ctrl),
        .fields    (fld),
        .last_byte (last_byte)
    );

    fvm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign sig_ok  = (fld.signature == BOOT_SIG);
    assign jump_ok = (fld.first_byte == JMP_SHORT) || (fld.first_byte == JMP_NEAR);
    assign bps_ok  = (fld.bytes_per_sector == 16'(SECTOR_BYTES));
    assign type_ok = (fld.part_type == TYPE_FAT32_CHS) || (fld.part_type == TYPE_FAT32_LBA);
    assign bpb_ok  = bps_ok && (fld.fat16_size == '0) && (fld.cluster_sectors != '0)
                  && (fld.reserved_count != '0) && (fld.fat_copies != '0)
                  && (fld.fat32_size != '0) && (fld.root_cluster >= 32'd2)
                  && (fld.total_sectors != '0);
    assign mounted   = (status_reg == ST_MOUNTED);
    assign prod_full = fld.fat_copies * fld.fat32_size;

    assign div_req.start    = (state_reg == S_DSEC);
    assign div_req.dividend = fld.total_sectors - span_reg;
    assign div_req.divisor  = fld.cluster_sectors;

    always_comb begin
        state_next      = state_reg;
        done_next       = done_reg;
        in_part_next    = in_part_reg;
        part_base_next  = part_base_reg;
        status_next     = status_reg;
        fat_start_next  = fat_start_reg;
        prod_next       = prod_reg;
        data_start_next = data_start_reg;
        span_next       = span_reg;
        maxc_next       = maxc_reg;
        cap_next        = cap_reg;

        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_request_lba_next  = m_request_lba_reg;
        m_fat_start_next    = m_fat_start_reg;
        m_data_start_next   = m_data_start_reg;
        m_sec_per_clus_next = m_sec_per_clus_reg;
        m_root_clus_next    = m_root_clus_reg;
        m_num_fats_next     = m_num_fats_reg;
        m_fat_size_next     = m_fat_size_reg;
        m_max_clus_next     = m_max_clus_reg;

        case (state_reg)
            S_BYTES: begin
                if (begin_go) begin
                    done_next      = 1'b0;
                    in_part_next   = 1'b0;
                    part_base_next = '0;
                end else if (fail_go) begin
                    done_next           = 1'b1;
                    m_valid_next        = 1'b1;
                    m_status_next       = ST_IO_ERR;
                    m_request_lba_next  = '0;
                    m_fat_start_next    = '0;
                    m_data_start_next   = '0;
                    m_sec_per_clus_next = '0;
                    m_root_clus_next    = '0;
                    m_num_fats_next     = '0;
                    m_fat_size_next     = '0;
                    m_max_clus_next     = '0;
                end else if (byte_go && last_byte) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                status_next = ST_NO_FS;
                state_next  = S_EMIT;
                if (in_part_reg) begin
                    if (sig_ok && bpb_ok) begin
                        status_next    = ST_MOUNTED;
                        fat_start_next = part_base_reg + 32'(fld.reserved_count);
                        state_next     = S_MUL;
                    end
                end else if (jump_ok && bps_ok && sig_ok) begin
                    if (bpb_ok) begin
                        status_next    = ST_MOUNTED;
                        fat_start_next = 32'(fld.reserved_count);
                        state_next     = S_MUL;
                    end
                end else if (sig_ok && type_ok && (fld.part_lba != '0)) begin
                    status_next    = ST_NEED_PART;
                    part_base_next = fld.part_lba;
                    in_part_next   = 1'b1;
                end
            end
            S_MUL: begin
                prod_next  = prod_full[31:0];
                state_next = S_SUM;
            end
            S_SUM: begin
                data_start_next = fat_start_reg + prod_reg;
                // data_start minus base, kept apart so the sector count is one subtract
                span_next       = 32'(fld.reserved_count) + prod_reg;
                state_next      = S_DSEC;
            end
            S_DSEC: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    maxc_next  = div_rsp.quotient + 32'd1;
                    cap_next   = (fld.fat32_size << CAP_SHIFT) - 32'd1;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (maxc_reg > cap_reg) begin
                    maxc_next = cap_reg;
                end
                state_next = S_CAP;
            end
            S_CAP: begin
                if (maxc_reg > MAX_CLUS_CAP) begin
                    maxc_next = MAX_CLUS_CAP;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = status_reg;
                    m_request_lba_next  = (status_reg == ST_NEED_PART) ? fld.part_lba : '0;
                    m_fat_start_next    = mounted ? fat_start_reg : '0;
                    m_data_start_next   = mounted ? data_start_reg : '0;
                    m_sec_per_clus_next = mounted ? fld.cluster_sectors : '0;
                    m_root_clus_next    = mounted ? fld.root_cluster : '0;
                    m_num_fats_next     = mounted ? fld.fat_copies : '0;
                    m_fat_size_next     = mounted ? fld.fat32_size : '0;
                    m_max_clus_next     = mounted ? maxc_reg[27:0] : '0;
                    done_next           = (status_reg != ST_NEED_PART);
                    state_next          = S_BYTES;
                end
            end
            default: begin
                state_next = S_BYTES;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_BYTES;
            done_reg      <= 1'b0;
            in_part_reg   <= 1'b0;
            part_base_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            in_part_reg   <= in_part_next;
            part_base_reg <= part_base_next;
            m_valid_reg   <= m_valid_next;
        end
        status_reg         <= status_next;
        fat_start_reg      <= fat_start_next;
        prod_reg           <= prod_next;
        data_start_reg     <= data_start_next;
        span_reg           <= span_next;
        maxc_reg           <= maxc_next;
        cap_reg            <= cap_next;
        m_status_reg       <= m_status_next;
        m_request_lba_reg  <= m_request_lba_next;
        m_fat_start_reg    <= m_fat_start_next;
        m_data_start_reg   <= m_data_start_next;
        m_sec_per_clus_reg <= m_sec_per_clus_next;
        m_root_clus_reg    <= m_root_clus_next;
        m_num_fats_reg     <= m_num_fats_next;
        m_fat_size_reg     <= m_fat_size_next;
        m_max_clus_reg     <= m_max_clus_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_request_lba  = m_request_lba_reg;
    assign m_fat_start    = m_fat_start_reg;
    assign m_data_start   = m_data_start_reg;
    assign m_sec_per_clus = m_sec_per_clus_reg;
    assign m_root_clus    = m_root_clus_reg;
    assign m_num_fats     = m_num_fats_reg;
    assign m_fat_size     = m_fat_size_reg;
    assign m_max_clus     = m_max_clus_reg;

endmodule

FILE: design/fvm_capture.sv
module fvm_capture (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fvm_pkg::cap_ctrl_t   ctrl,
    output fvm_pkg::bpb_fields_t fields,
    output logic                 last_byte
);
    import fvm_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    bpb_fields_t      fld_reg, fld_next;

    assign last_byte = (idx_reg == IDX_W'(SECTOR_BYTES - 1));
    assign fields    = fld_reg;

    always_comb begin
        idx_next = idx_reg;
        fld_next = fld_reg;
        if (ctrl.clear) begin
            idx_next = '0;
            fld_next = '0;
        end else if (ctrl.write) begin
            // wrap at sector end; a partition sector starts again from offset 0
            idx_next = last_byte ? '0 : idx_reg + IDX_W'(1);
            case (idx_reg)
                IDX_W'(OFS_JUMP):      fld_next.first_byte             = ctrl.data;
                IDX_W'(OFS_BPS):       fld_next.bytes_per_sector[7:0]  = ctrl.data;
                IDX_W'(OFS_BPS + 1):   fld_next.bytes_per_sector[15:8] = ctrl.data;
                IDX_W'(OFS_SPC):       fld_next.cluster_sectors        = ctrl.data;
                IDX_W'(OFS_RSV):       fld_next.reserved_count[7:0]    = ctrl.data;
                IDX_W'(OFS_RSV + 1):   fld_next.reserved_count[15:8]   = ctrl.data;
                IDX_W'(OFS_NFATS):     fld_next.fat_copies             = ctrl.data;
                IDX_W'(OFS_FAT16):     fld_next.fat16_size[7:0]        = ctrl.data;
                IDX_W'(OFS_FAT16 + 1): fld_next.fat16_size[15:8]       = ctrl.data;
                IDX_W'(OFS_TOTAL):     fld_next.total_sectors[7:0]     = ctrl.data;
                IDX_W'(OFS_TOTAL + 1): fld_next.total_sectors[15:8]    = ctrl.data;
                IDX_W'(OFS_TOTAL + 2): fld_next.total_sectors[23:16]   = ctrl.data;
                IDX_W'(OFS_TOTAL + 3): fld_next.total_sectors[31:24]   = ctrl.data;
                IDX_W'(OFS_FAT32):     fld_next.fat32_size[7:0]        = ctrl.data;
                IDX_W'(OFS_FAT32 + 1): fld_next.fat32_size[15:8]       = ctrl.data;
                IDX_W'(OFS_FAT32 + 2): fld_next.fat32_size[23:16]      = ctrl.data;
                IDX_W'(OFS_FAT32 + 3): fld_next.fat32_size[31:24]      = ctrl.data;
                IDX_W'(OFS_ROOT):      fld_next.root_cluster[7:0]      = ctrl.data;
                IDX_W'(OFS_ROOT + 1):  fld_next.root_cluster[15:8]     = ctrl.data;
                IDX_W'(OFS_ROOT + 2):  fld_next.root_cluster[23:16]    = ctrl.data;
                IDX_W'(OFS_ROOT + 3):  fld_next.root_cluster[31:24]    = ctrl.data;
                IDX_W'(OFS_PTYPE):     fld_next.part_type              = ctrl.data;
                IDX_W'(OFS_PLBA):      fld_next.part_lba[7:0]          = ctrl.data;
                IDX_W'(OFS_PLBA + 1):  fld_next.part_lba[15:8]         = ctrl.data;
                IDX_W'(OFS_PLBA + 2):  fld_next.part_lba[23:16]        = ctrl.data;
                IDX_W'(OFS_PLBA + 3):  fld_next.part_lba[31:24]        = ctrl.data;
                IDX_W'(OFS_SIG):       fld_next.signature[7:0]         = ctrl.data;
                IDX_W'(OFS_SIG + 1):   fld_next.signature[15:8]        = ctrl.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            fld_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            fld_reg <= fld_next;
        end
    end

endmodule

FILE: design/fvm_divider.sv
module fvm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  fvm_pkg::div_req_t req,
    output fvm_pkg::div_rsp_t rsp
);
    import fvm_pkg::*;

    logic [31:0]          dvd_reg, dvd_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [8:0]           rem_sh;
    logic [8:0]           rem_sub;

    // one restoring step per cycle; quotient bits shift in behind the dividend
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sub[7:0];
                dvd_next = {dvd_reg[30:0], 1'b1};
            end else begin
                rem_next = rem_sh[7:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

FILE: design/fvm_checker.sv
module fvm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_cmd,
    input logic [7:0]  s_data_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_request_lba,
    input logic [31:0] m_fat_start,
    input logic [31:0] m_data_start,
    input logic [7:0]  m_sec_per_clus,
    input logic [31:0] m_root_clus,
    input logic [7:0]  m_num_fats,
    input logic [31:0] m_fat_size,
    input logic [27:0] m_max_clus
);
    import fvm_pkg::*;

    // a stalled result beat holds its status and cluster count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_max_clus))
        else $error("result beat changed while stalled");

    // no input beat is taken while an untaken result would be overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid || m_ready)
        else $error("input taken while result slot busy");

    // geometry only goes out with a mounted status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_MOUNTED) |-> (m_fat_start == '0) && (m_data_start == '0)
            && (m_fat_size == '0) && (m_max_clus == '0))
        else $error("geometry on a non-mounted result");

    // a partition request never points at sector zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NEED_PART) |-> (m_request_lba != '0))
        else $error("partition request for LBA zero");

    // cluster count respects the FAT32 ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_MOUNTED) |-> (32'(m_max_clus) <= MAX_CLUS_CAP))
        else $error("max cluster above ceiling");

endmodule

bind fat32_volume_mount_parser_core fvm_checker u_fvm_checker (.*);
